### design/eeg_delta_packetizer_defines.svh
// Assertion macros shared by the packetizer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef EEG_DELTA_PACKETIZER_DEFINES_SVH
`define EEG_DELTA_PACKETIZER_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define EDP_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("edp: same-cycle check failed");

// antecedent holds -> consequent holds in the next cycle
`define EDP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("edp: next-cycle check failed");

// condition must never be seen out of reset
`define EDP_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("edp: forbidden condition seen");

`endif

### design/edp_pkg.sv
// Shared constants, types and helpers for the EEG delta packetizer.
// No dependencies; imported by every module of the block.
package edp_pkg;

  localparam int unsigned SamplesPerPacket = 32;
  localparam int unsigned NumBanks         = 2;

  localparam int unsigned RawW      = 16;
  localparam int unsigned SampleW   = 10;
  localparam int unsigned SampleLsb = 6;
  localparam int unsigned CodeW     = 11;
  localparam int unsigned SlotOutW  = 6;

  // counter must hold SamplesPerPacket + 1
  localparam int unsigned SlotW = $clog2(SamplesPerPacket + 2);
  localparam int unsigned BankW = (NumBanks > 1) ? $clog2(NumBanks) : 1;

  localparam logic [SlotW-1:0] SlotTop  = SlotW'(SamplesPerPacket + 1);
  localparam logic [SlotW-1:0] SlotWrap = SlotW'(SamplesPerPacket);
  localparam logic [BankW-1:0] BankLast = BankW'(NumBanks - 1);

  localparam logic signed [CodeW-1:0] DiffMax = 11'sd127;
  localparam logic signed [CodeW-1:0] DiffMin = -11'sd128;
  localparam logic [SampleW-1:0]      SlewUp   = 10'd127;
  localparam logic [SampleW-1:0]      SlewDown = 10'd128;

  // func / kind codes
  localparam logic FuncSnap    = 1'b0;
  localparam logic FuncStart   = 1'b1;
  localparam logic KindSample  = 1'b0;
  localparam logic KindClosed  = 1'b1;

  localparam int unsigned InDataW  = 4 * RawW;
  localparam int unsigned OutBitsW = SlotOutW + 2 * CodeW + 1 + 2 * SampleW;
  localparam int unsigned OutDataW = ((OutBitsW + 7) / 8) * 8;

  typedef struct packed {
    logic                    kind;
    logic [SlotOutW-1:0]     slot;
    logic signed [CodeW-1:0] left_code;
    logic signed [CodeW-1:0] right_code;
    logic                    closed_bank;
    logic [SampleW-1:0]      left_emg_peak;
    logic [SampleW-1:0]      right_emg_peak;
  } result_t;

  function automatic logic [SampleW-1:0] take_sample(input logic [RawW-1:0] raw);
    return raw[SampleLsb +: SampleW];
  endfunction

endpackage

### design/edp_eeg_lane.sv
// One EEG channel: tracked value and slew-limited delta coder.
// Depends on edp_pkg.
module edp_eeg_lane (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               snap_i,
  input  logic                               first_i,
  input  logic [edp_pkg::RawW-1:0]           raw_i,
  output logic signed [edp_pkg::CodeW-1:0]   code_o
);
  import edp_pkg::*;

  logic [SampleW-1:0]      tracked_q, tracked_d;
  logic [SampleW-1:0]      x;
  logic signed [CodeW-1:0] diff;

  assign x    = take_sample(raw_i);
  assign diff = $signed({1'b0, x}) - $signed({1'b0, tracked_q});

  always_comb begin
    priority if (first_i) begin
      tracked_d = x;
      code_o    = $signed({1'b0, x});
    end else if (diff > DiffMax) begin
      tracked_d = tracked_q + SlewUp;
      code_o    = DiffMax;
    end else if (diff < DiffMin) begin
      tracked_d = tracked_q - SlewDown;
      code_o    = DiffMin;
    end else begin
      tracked_d = x;
      code_o    = diff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracked_q <= '0;
    end else if (snap_i) begin
      tracked_q <= tracked_d;
    end
  end

endmodule

### design/edp_peak_lane.sv
// One EMG channel: running maximum over the open packet.
// Depends on edp_pkg.
module edp_peak_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          snap_i,
  input  logic                          clear_i,
  input  logic [edp_pkg::RawW-1:0]      raw_i,
  output logic [edp_pkg::SampleW-1:0]   peak_o
);
  import edp_pkg::*;

  logic [SampleW-1:0] peak_q, peak_d;
  logic [SampleW-1:0] v;

  assign v = take_sample(raw_i);

  always_comb begin
    peak_d = peak_q;
    priority if (clear_i) begin
      peak_d = '0;
    end else if (snap_i && (v > peak_q)) begin
      peak_d = v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
    end else begin
      peak_q <= peak_d;
    end
  end

  assign peak_o = peak_q;

endmodule

### design/edp_merge.sv
// Merges lane results into one result word and holds it in the output register.
// Depends on edp_pkg.
module edp_merge (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  logic                               kind_i,
  input  logic [edp_pkg::SlotOutW-1:0]       slot_i,
  input  logic signed [edp_pkg::CodeW-1:0]   left_code_i,
  input  logic signed [edp_pkg::CodeW-1:0]   right_code_i,
  input  logic                               bank_i,
  input  logic [edp_pkg::SampleW-1:0]        left_peak_i,
  input  logic [edp_pkg::SampleW-1:0]        right_peak_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output edp_pkg::result_t                   result_o
);
  import edp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  // unused fields of each kind read as zero
  always_comb begin
    res_d      = '0;
    res_d.kind = kind_i;
    unique case (kind_i)
      KindClosed: begin
        res_d.closed_bank    = bank_i;
        res_d.left_emg_peak  = left_peak_i;
        res_d.right_emg_peak = right_peak_i;
      end
      KindSample: begin
        res_d.slot       = slot_i;
        res_d.left_code  = left_code_i;
        res_d.right_code = right_code_i;
      end
      default: ;
    endcase
  end

  always_comb begin
    priority if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

### design/eeg_delta_packetizer.sv
// EEG delta packetizer. One word in, one word out, one word per clock sustained.
// Each input word is fully processed in the cycle it is taken: the two EEG lanes
// (subtract, clamp) and the two EMG peak lanes work in parallel, and the result
// appears on the output register on the next cycle. The only thing that stalls the
// input is a full output register that the downstream side has not taken, so
// throughput is one word per cycle while m_axis_tready is high. A start word
// (tuser = 1) closes the packet and returns the finished bank and EMG peaks; a snap
// word (tuser = 0) returns the slot and the two EEG codes, full value at slot 0 and
// a saturated -128..127 difference thereafter.
`include "eeg_delta_packetizer_defines.svh"

module eeg_delta_packetizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] left_eeg_raw, [31:16] right_eeg_raw, [47:32] left_emg_raw,
  // [63:48] right_emg_raw
  input  logic [edp_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] func
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [5:0] slot, [16:6] left_code, [27:17] right_code, [28] closed_bank,
  // [38:29] left_emg_peak, [48:39] right_emg_peak, [55:49] zero
  output logic [edp_pkg::OutDataW-1:0]  m_axis_tdata,
  // [0] kind
  output logic                          m_axis_tuser
);
  import edp_pkg::*;

  logic               accept, snap, start;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic [BankW-1:0]   bank_q, bank_d;
  logic signed [CodeW-1:0] left_code, right_code;
  logic [SampleW-1:0] left_peak, right_peak;
  result_t            res;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign snap   = accept && (s_axis_tuser == FuncSnap);
  assign start  = accept && (s_axis_tuser == FuncStart);

  always_comb begin
    slot_d = slot_q;
    bank_d = bank_q;
    if (start) begin
      slot_d = '0;
      bank_d = (bank_q == BankLast) ? '0 : bank_q + 1'b1;
    end else if (snap) begin
      slot_d = (slot_q == SlotTop) ? SlotWrap : slot_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      bank_q <= '0;
    end else begin
      slot_q <= slot_d;
      bank_q <= bank_d;
    end
  end

  edp_eeg_lane u_left_eeg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .snap_i  (snap),
    .first_i (slot_q == '0),
    .raw_i   (s_axis_tdata[0*RawW +: RawW]),
    .code_o  (left_code)
  );

  edp_eeg_lane u_right_eeg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .snap_i  (snap),
    .first_i (slot_q == '0),
    .raw_i   (s_axis_tdata[1*RawW +: RawW]),
    .code_o  (right_code)
  );

  edp_peak_lane u_left_emg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .snap_i  (snap),
    .clear_i (start),
    .raw_i   (s_axis_tdata[2*RawW +: RawW]),
    .peak_o  (left_peak)
  );

  edp_peak_lane u_right_emg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .snap_i  (snap),
    .clear_i (start),
    .raw_i   (s_axis_tdata[3*RawW +: RawW]),
    .peak_o  (right_peak)
  );

  edp_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .kind_i       (s_axis_tuser),
    .slot_i       (SlotOutW'(slot_q)),
    .left_code_i  (left_code),
    .right_code_i (right_code),
    .bank_i       (bank_q[0]),
    .left_peak_i  (left_peak),
    .right_peak_i (right_peak),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .result_o     (res)
  );

  // output register frees up in the same cycle it is drained
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;

  assign m_axis_tuser = res.kind;
  assign m_axis_tdata = OutDataW'({res.right_emg_peak, res.left_emg_peak, res.closed_bank,
                                   res.right_code, res.left_code, res.slot});

  `EDP_ASSERT_NEVER(a_slot_cap, clk_i, rst_ni, slot_q > SlotTop)
  `EDP_ASSERT_NEXT(a_start_rewinds, clk_i, rst_ni, start,
                   (slot_q == '0) && (left_peak == '0) && (right_peak == '0))
  `EDP_ASSERT_NEXT(a_word_out, clk_i, rst_ni, accept, m_axis_tvalid)
  `EDP_ASSERT_IMPL(a_hold_stalls, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   !s_axis_tready)

endmodule

### tb/sv/eeg_packet_checker.sv
`timescale 1ns / 1ps
// Checker for the EEG delta packetizer: predicts each output word from the accepted
// input words and compares it field by field. Depends on edp_pkg only.
module eeg_packet_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [edp_pkg::InDataW-1:0]  in_data_i,
  input  logic                         in_user_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [edp_pkg::OutDataW-1:0] out_data_i,
  input  logic                         out_user_i,
  output int                           errors_o,
  output int                           pending_o
);
  import edp_pkg::*;

  localparam int unsigned LeftLsb  = SlotOutW;
  localparam int unsigned RightLsb = SlotOutW + CodeW;
  localparam int unsigned BankLsb  = SlotOutW + 2 * CodeW;
  localparam int unsigned LPeakLsb = BankLsb + 1;
  localparam int unsigned RPeakLsb = LPeakLsb + SampleW;

  typedef struct packed {
    logic signed [CodeW-1:0] code;
    logic [SampleW-1:0]      trk;
  } lane_t;

  // shadow of the block's state
  logic [SampleW-1:0] left_trk, right_trk, left_peak, right_peak;
  int unsigned        slot_cnt;
  int unsigned        bank;
  int                 err_count;
  result_t            expected_words[$];

  // full value at slot 0, else the slew-limited difference
  function automatic lane_t slew_code(input logic [SampleW-1:0] x,
                                      input logic [SampleW-1:0] trk, input bit first);
    lane_t o;
    int    d;
    d = int'(x) - int'(trk);
    if (first) begin
      o.code = CodeW'(x);
      o.trk  = x;
    end else if (d > int'(DiffMax)) begin
      o.code = DiffMax;
      o.trk  = trk + SlewUp;
    end else if (d < int'(DiffMin)) begin
      o.code = DiffMin;
      o.trk  = trk - SlewDown;
    end else begin
      o.code = CodeW'(d);
      o.trk  = x;
    end
    return o;
  endfunction

  function automatic result_t predict_word(input logic func, input logic [InDataW-1:0] data);
    result_t            r;
    lane_t              lo, ro;
    logic [SampleW-1:0] lm, rm;
    bit                 first;
    r = '0;
    if (func == FuncStart) begin
      r.kind           = KindClosed;
      r.closed_bank    = bank[0];
      r.left_emg_peak  = left_peak;
      r.right_emg_peak = right_peak;
      left_peak  = '0;
      right_peak = '0;
      slot_cnt   = 0;
      bank       = (bank >= NumBanks - 1) ? 0 : bank + 1;
    end else begin
      first        = (slot_cnt == 0);
      r.kind       = KindSample;
      r.slot       = SlotOutW'(slot_cnt);
      lo           = slew_code(data[SampleLsb +: SampleW], left_trk, first);
      ro           = slew_code(data[RawW + SampleLsb +: SampleW], right_trk, first);
      left_trk     = lo.trk;
      right_trk    = ro.trk;
      r.left_code  = lo.code;
      r.right_code = ro.code;
      // counter sticks between the two highest slots if the packet is never closed
      slot_cnt = slot_cnt + 1;
      if (slot_cnt > SamplesPerPacket + 1) slot_cnt = SamplesPerPacket;
      lm = data[2 * RawW + SampleLsb +: SampleW];
      rm = data[3 * RawW + SampleLsb +: SampleW];
      if (lm > left_peak) left_peak = lm;
      if (rm > right_peak) right_peak = rm;
    end
    return r;
  endfunction

  function automatic int field_differs(input string name, input int want, input int got);
    if (want == got) return 0;
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_trk   = '0;
      right_trk  = '0;
      left_peak  = '0;
      right_peak = '0;
      slot_cnt   = 0;
      bank       = 0;
      err_count  = 0;
      errors_o   <= 0;
      pending_o  <= 0;
      expected_words.delete();
    end else begin : watch
      result_t want;
      result_t got;
      if (in_valid_i && in_ready_i) expected_words.push_back(predict_word(in_user_i, in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t ns: output word with none expected, got %h", $time, out_data_i);
          err_count = err_count + 1;
        end else begin
          want = expected_words.pop_front();
          got.kind           = out_user_i;
          got.slot           = out_data_i[SlotOutW-1:0];
          got.left_code      = out_data_i[LeftLsb +: CodeW];
          got.right_code     = out_data_i[RightLsb +: CodeW];
          got.closed_bank    = out_data_i[BankLsb];
          got.left_emg_peak  = out_data_i[LPeakLsb +: SampleW];
          got.right_emg_peak = out_data_i[RPeakLsb +: SampleW];
          err_count = err_count
            + field_differs("kind", int'(want.kind), int'(got.kind))
            + field_differs("slot", int'(want.slot), int'(got.slot))
            + field_differs("left_code", int'(want.left_code), int'(got.left_code))
            + field_differs("right_code", int'(want.right_code), int'(got.right_code))
            + field_differs("closed_bank", int'(want.closed_bank), int'(got.closed_bank))
            + field_differs("left_emg_peak", int'(want.left_emg_peak),
                            int'(got.left_emg_peak))
            + field_differs("right_emg_peak", int'(want.right_emg_peak),
                            int'(got.right_emg_peak))
            + field_differs("padding", 0, int'(out_data_i[OutDataW-1:OutBitsW]));
        end
      end
      errors_o  <= err_count;
      pending_o <= expected_words.size();
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the packetizer testbench: clock, reset, stimulus and receiver back-pressure.
// Depends on edp_pkg, eeg_delta_packetizer and eeg_packet_checker.
module tb;
  import edp_pkg::*;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  int                  errors;
  int                  pending;
  int                  sent      = 0;
  bit                  steady    = 1'b0;
  bit                  hold_req  = 1'b0;
  logic [SampleW-1:0]  left_last  = '0;
  logic [SampleW-1:0]  right_last = '0;

  eeg_delta_packetizer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  eeg_packet_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .out_user_i  (m_axis_tuser),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request, none while steady
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 23);
      end
    end
  end

  // valid is only lowered when a gap follows, so it never toggles within a step
  task automatic send_word(input logic func, input logic [RawW-1:0] l_eeg,
                           input logic [RawW-1:0] r_eeg, input logic [RawW-1:0] l_emg,
                           input logic [RawW-1:0] r_emg);
    if (!steady) begin
      while ($urandom_range(0, 99) < 23) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {r_emg, l_emg, r_eeg, l_eeg};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  // mostly close to the previous sample so that many differences stay unsaturated
  function automatic logic [RawW-1:0] eeg_word(input logic [SampleW-1:0] last);
    int v;
    int off;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      v = $urandom_range(0, 1023);
    end else if (pick == 3) begin
      v = $urandom_range(0, 1) ? 1023 : 0;
    end else begin
      off = $urandom_range(0, 280);
      v   = int'(last) + off - 140;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
    end
    return {v[SampleW-1:0], 6'($urandom)};
  endfunction

  task automatic send_snap();
    logic [RawW-1:0] le;
    logic [RawW-1:0] re;
    le = eeg_word(left_last);
    re = eeg_word(right_last);
    left_last  = le[RawW-1:SampleLsb];
    right_last = re[RawW-1:SampleLsb];
    send_word(FuncSnap, le, re, 16'($urandom), 16'($urandom));
  endtask

  initial begin : stimulus
    int  plen;
    bit  hold_done;
    hold_done = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full-scale first sample, then saturating and exact-limit differences
    send_word(FuncSnap,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(FuncSnap,  16'h0000, 16'h0000, 16'h0040, 16'h0000);
    send_word(FuncSnap,  16'(767 << 6), 16'(1022 << 6), 16'h0000, 16'h0040);
    send_word(FuncSnap,  16'(895 << 6), 16'(893 << 6), 16'h8000, 16'h7FC0);
    // low six bits carry nothing
    send_word(FuncSnap,  16'(894 << 6) | 16'h003F, 16'h003F, 16'h003F, 16'hFFC0);
    send_word(FuncStart, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // empty packets, bank wraps
    send_word(FuncStart, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(FuncStart, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    send_word(FuncSnap,  16'h8000, 16'h7FFF, 16'hFFC0, 16'h0000);
    send_word(FuncSnap,  16'h0000, 16'hFFFF, 16'h0040, 16'h0000);
    send_word(FuncSnap,  16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    send_word(FuncStart, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    left_last  = '0;
    right_last = '0;

    // random packets; some run past the slot cap before being closed
    while (sent < 540) begin
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 40) : $urandom_range(0, 12);
      for (int i = 0; i < plen; i++) begin
        steady = (sent >= 420 && sent < 490);
        if (!hold_done && sent >= 250) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        send_snap();
      end
      send_word(FuncStart, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
    steady = 1'b0;

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/edp_pkg.sv
design/edp_eeg_lane.sv
design/edp_peak_lane.sv
design/edp_merge.sv
design/eeg_delta_packetizer.sv
tb/sv/eeg_packet_checker.sv
tb/sv/tb.sv
